### rtl/core/particle_reading_frame_parser_unit_macros.svh
// Assertion macros used by the checker file of the frame parser.
`ifndef PARTICLE_READING_FRAME_PARSER_UNIT_MACROS_SVH
`define PARTICLE_READING_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, disabled during reset.
`define PRFP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

### rtl/core/prfp_pkg.sv
// Package with types, codes and constants of the particle reading frame parser.
package prfp_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] HEAD_FIRST  = 8'h40;
  localparam logic [7:0] HEAD_SECOND = 8'h0D;
  localparam logic [3:0] FIRST_READING_POS = 4'd3;
  localparam logic [3:0] LAST_READING_POS  = 4'd10;
  localparam logic [3:0] LAST_SUM_POS      = 4'd14;
  localparam logic [3:0] LAST_POS          = 4'd15;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_HDR = 2'd1;
  localparam logic [1:0] STATUS_SUM = 2'd2;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_SUM     = 3'd1;
  localparam logic [2:0] OP_CAPTURE = 3'd2;
  localparam logic [2:0] OP_HDR_ERR = 3'd3;
  localparam logic [2:0] OP_CHECK   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] idx;
    logic [7:0] data;
  } cmd_t;

endpackage

### rtl/core/prfp_if.sv
// Channel interfaces of the frame parser: received bytes in, readings out.
interface prfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface prfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pm_1_0;
  logic [15:0] pm_2_5;
  logic [15:0] pm_4_0;
  logic [15:0] pm_10;

  modport source (output valid, output status, output pm_1_0, output pm_2_5,
                  output pm_4_0, output pm_10, input ready);
  modport sink   (input valid, input status, input pm_1_0, input pm_2_5,
                  input pm_4_0, input pm_10, output ready);
endinterface

### rtl/core/prfp_front.sv
// Front end: tracks the frame position and classifies each byte into a command.
module prfp_front import prfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  prfp_byte_if.sink     rx,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cmd_t          cmd
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic       first_bad;
  logic       first_bad_next;
  logic       take;

  assign rx.ready  = cmd_ready;
  assign cmd_valid = rx.valid;
  assign take      = rx.valid && cmd_ready;

  always_comb begin
    pos_next       = pos;
    first_bad_next = first_bad;
    cmd.data       = rx.rx_byte;
    cmd.idx        = 3'(pos - FIRST_READING_POS);
    cmd.op         = OP_SUM;
    case (pos)
      4'd0: begin
        cmd.op         = OP_START;
        first_bad_next = (rx.rx_byte != HEAD_FIRST);
        pos_next       = 4'd1;
      end
      4'd1: begin
        if (first_bad || rx.rx_byte != HEAD_SECOND) begin
          cmd.op         = OP_HDR_ERR;
          first_bad_next = 1'b0;
          pos_next       = 4'd0;
        end else begin
          cmd.op   = OP_SUM;
          pos_next = 4'd2;
        end
      end
      LAST_POS: begin
        cmd.op         = OP_CHECK;
        first_bad_next = 1'b0;
        pos_next       = 4'd0;
      end
      default: begin
        if (pos inside {[FIRST_READING_POS:LAST_READING_POS]}) begin
          cmd.op = OP_CAPTURE;
        end else begin
          cmd.op = OP_SUM;
        end
        pos_next = pos + 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 4'd0;
      first_bad <= 1'b0;
    end else if (take) begin
      pos       <= pos_next;
      first_bad <= first_bad_next;
    end
  end

endmodule

### rtl/core/prfp_queue.sv
// Short command queue between the front end and the back end.
module prfp_queue import prfp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/prfp_back.sv
// Back end: running sum, reading capture, checksum test and the result register.
module prfp_back import prfp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  cmd_t           cmd,
  prfp_result_if.source  res
);

  logic [7:0] sum;
  logic [7:0] readings [8];
  logic       is_result;
  logic       pop;
  logic       load;
  logic       out_valid;

  assign is_result = (cmd.op == OP_HDR_ERR) || (cmd.op == OP_CHECK);
  // Results wait for room in the output register; other commands never stall.
  assign cmd_ready = !is_result || !out_valid || res.ready;
  assign pop       = cmd_valid && cmd_ready;
  assign load      = pop && is_result;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        case (cmd.op)
          OP_START:             sum <= cmd.data;
          OP_SUM, OP_CAPTURE:   sum <= sum + cmd.data;
          OP_HDR_ERR, OP_CHECK: sum <= 8'd0;
          default:              sum <= sum;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.op == OP_CAPTURE) begin
      readings[cmd.idx] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.op == OP_HDR_ERR) begin
        res.status <= STATUS_HDR;
        res.pm_1_0 <= 16'd0;
        res.pm_2_5 <= 16'd0;
        res.pm_4_0 <= 16'd0;
        res.pm_10  <= 16'd0;
      end else begin
        res.status <= (cmd.data == 8'(8'd0 - sum)) ? STATUS_OK : STATUS_SUM;
        res.pm_1_0 <= {readings[0], readings[1]};
        res.pm_2_5 <= {readings[2], readings[3]};
        res.pm_4_0 <= {readings[4], readings[5]};
        res.pm_10  <= {readings[6], readings[7]};
      end
    end
  end

endmodule

### rtl/core/particle_reading_frame_parser_unit.sv
// Top level of the particle reading frame parser.
// Usage: feed the received bytes of a 16-byte sensor response frame on the
// rx channel (rx_byte), one request per byte, in arrival order. The res
// channel returns one request per frame: status (ok, header mismatch,
// checksum mismatch) and the readings pm_1_0, pm_2_5, pm_4_0 and pm_10.
// A header mismatch is reported after byte 1 with zero readings; the next
// byte starts a new frame. A checksum mismatch still carries the readings.
// Throughput: one byte per cycle while res keeps up; the front end classifies
// each byte combinationally and the back end retires one command per cycle
// until a result waits on res. Result path: the command of the last byte
// enters the queue when the byte is accepted and moves into the output
// register when the back end pops it, where res can take it.
// Receiver stall: the output register holds its result, the back end stops
// at the next result command, the command queue (QUEUE_DEPTH entries) fills
// and then rx.ready drops. Other commands wait on res only behind a result.
// Reset: synchronous rst clears the frame position, the sum, the queue and
// the output valid; the block accepts bytes in the first cycle after reset.
module particle_reading_frame_parser_unit import prfp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  prfp_byte_if.sink     rx,
  prfp_result_if.source res
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  prfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  prfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  prfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .res       (res)
  );

endmodule

### rtl/core/prfp_checker.sv
// Port-level checker of the frame parser, bound to the top level.
`include "particle_reading_frame_parser_unit_macros.svh"

module prfp_checker import prfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] pm_1_0,
  input logic [15:0] pm_2_5,
  input logic [15:0] pm_4_0,
  input logic [15:0] pm_10
);

  `PRFP_ASSERT_NXT(a_res_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(pm_1_0) && $stable(pm_10))
  `PRFP_ASSERT_NOW(a_status_code, clk, rst, out_valid,
    status == STATUS_OK || status == STATUS_HDR || status == STATUS_SUM)
  `PRFP_ASSERT_NOW(a_hdr_zero, clk, rst, out_valid && status == STATUS_HDR,
    pm_1_0 == 16'd0 && pm_2_5 == 16'd0 && pm_4_0 == 16'd0 && pm_10 == 16'd0)
  `PRFP_ASSERT_NOW(a_reset_idle, clk, rst, $past(rst), !out_valid)

endmodule

bind particle_reading_frame_parser_unit prfp_checker u_prfp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .status    (res.status),
  .pm_1_0    (res.pm_1_0),
  .pm_2_5    (res.pm_2_5),
  .pm_4_0    (res.pm_4_0),
  .pm_10     (res.pm_10)
);
